>>> design/tajtd_pkg.sv
// ----------------------------------------------------------------------------
// tajtd_pkg: shared types and constants of the jerk threshold detector
// Widths of the sample, time and jerk fields, and the lane status struct.
// ----------------------------------------------------------------------------
package tajtd_pkg;

   localparam int SampleWidth = 16;
   localparam int TimeWidth   = 32;
   localparam int JerkWidth   = 24;
   localparam int ThreshWidth = 23;
   localparam int DiffWidth   = 17;
   localparam int MagWidth    = 16;  // magnitude of a 17-bit difference is at most 65535
   localparam int ProdWidth   = 23;  // 65535 * 125 < 2^23
   localparam int NumLanes    = 3;
   localparam int StepWidth   = 5;   // counts the 23 quotient steps
   localparam logic [ThreshWidth-1:0] ThreshReset = 23'd5120;
   localparam logic [6:0] JerkMul = 7'd125;

   localparam logic [1:0] AxisX = 2'd0;
   localparam logic [1:0] AxisY = 2'd1;
   localparam logic [1:0] AxisZ = 2'd2;

   typedef struct packed {
      logic                 neg;
      logic [ProdWidth-1:0] mag;
   } lane_result_type;

endpackage

>>> design/tajtd_lane.sv
// ----------------------------------------------------------------------------
// tajtd_lane: one axis lane
// Forms |diff| * 125 in ST_MUL, then divides it by dt one quotient bit per
// cycle with a restoring divider.
// ----------------------------------------------------------------------------
module tajtd_lane (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   input  logic signed [tajtd_pkg::SampleWidth-1:0] now_sample,
   input  logic signed [tajtd_pkg::SampleWidth-1:0] prev_sample,
   input  logic [tajtd_pkg::TimeWidth-1:0]        dt,
   output logic                                   done,
   output tajtd_pkg::lane_result_type             result
);

   typedef enum logic [1:0] {ST_IDLE, ST_MUL, ST_DIV} state_type;

   state_type                            state_ff;
   logic [tajtd_pkg::StepWidth-1:0]      step_ff;
   logic                                 neg_ff;
   logic [tajtd_pkg::MagWidth-1:0]       mag_ff;
   logic [tajtd_pkg::ProdWidth-1:0]      quo_ff;
   logic [tajtd_pkg::TimeWidth:0]        rem_ff;
   logic [tajtd_pkg::TimeWidth-1:0]      dt_ff;
   logic                                 done_ff;

   logic signed [tajtd_pkg::DiffWidth-1:0] diff;
   logic [tajtd_pkg::DiffWidth-1:0]        diff_abs;
   logic [tajtd_pkg::TimeWidth:0]          rem_shift;
   logic [tajtd_pkg::TimeWidth:0]          rem_in;
   logic                                   fits;

   assign diff = tajtd_pkg::DiffWidth'(now_sample) - tajtd_pkg::DiffWidth'(prev_sample);
   assign diff_abs = diff[tajtd_pkg::DiffWidth-1] ? (-diff) : diff;
   assign rem_shift = {rem_ff[tajtd_pkg::TimeWidth-1:0], quo_ff[tajtd_pkg::ProdWidth-1]};
   assign fits = rem_shift >= {1'b0, dt_ff};
   assign rem_in = fits ? rem_shift - {1'b0, dt_ff} : rem_shift;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  neg_ff   <= diff[tajtd_pkg::DiffWidth-1];
                  mag_ff   <= diff_abs[tajtd_pkg::MagWidth-1:0];
                  dt_ff    <= dt;
                  state_ff <= ST_MUL;
               end
            end
            ST_MUL: begin
               quo_ff   <= tajtd_pkg::ProdWidth'(mag_ff) *
                           tajtd_pkg::ProdWidth'(tajtd_pkg::JerkMul);
               rem_ff   <= '0;
               step_ff  <= '0;
               state_ff <= ST_DIV;
            end
            ST_DIV: begin
               rem_ff <= rem_in;
               quo_ff <= {quo_ff[tajtd_pkg::ProdWidth-2:0], fits};
               step_ff <= step_ff + 1'b1;
               if (step_ff == tajtd_pkg::StepWidth'(tajtd_pkg::ProdWidth - 1)) begin
                  done_ff  <= 1'b1;
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign done = done_ff;
   assign result.neg = neg_ff;
   assign result.mag = quo_ff;

   property p_done_from_div;
      @(posedge clock) disable iff (reset) done |-> $past(state_ff == ST_DIV);
   endproperty
   a_done_from_div: assert property (p_done_from_div) else $error("lane done out of order");

   property p_dt_nonzero;
      @(posedge clock) disable iff (reset) state_ff == ST_DIV |-> dt_ff != '0;
   endproperty
   a_dt_nonzero: assert property (p_dt_nonzero) else $error("lane divides by zero");

   a_mag_bound: assert property (@(posedge clock) disable iff (reset)
      done |-> quo_ff <= tajtd_pkg::ProdWidth'(23'd8191875)) else $error("jerk too large");

endmodule

>>> design/tajtd_merge.sv
// ----------------------------------------------------------------------------
// tajtd_merge: compares lane results to the threshold and sends the alert run
// Holds the three signed jerks and hands them out X, Y, Z on the response side.
// ----------------------------------------------------------------------------
module tajtd_merge (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 lanes_done,
   input  tajtd_pkg::lane_result_type           lane_x,
   input  tajtd_pkg::lane_result_type           lane_y,
   input  tajtd_pkg::lane_result_type           lane_z,
   input  logic [tajtd_pkg::ThreshWidth-1:0]    threshold,
   output logic                                 idle,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [1:0]                           rsp_axis,
   output logic signed [tajtd_pkg::JerkWidth-1:0] rsp_jerk_value,
   output logic                                 rsp_last
);

   logic signed [tajtd_pkg::JerkWidth-1:0] jerk_ff [tajtd_pkg::NumLanes];
   logic [1:0]                             axis_ff;
   logic                                   valid_ff;
   logic                                   alert;

   function automatic logic signed [tajtd_pkg::JerkWidth-1:0] to_signed(
      tajtd_pkg::lane_result_type r);
      logic signed [tajtd_pkg::JerkWidth-1:0] m;
      m = tajtd_pkg::JerkWidth'(r.mag);
      return r.neg ? -m : m;
   endfunction

   assign alert = ({1'b0, lane_x.mag} > {1'b0, threshold}) ||
                  ({1'b0, lane_y.mag} > {1'b0, threshold}) ||
                  ({1'b0, lane_z.mag} > {1'b0, threshold});

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         axis_ff  <= tajtd_pkg::AxisX;
      end else begin
         if (lanes_done && alert) begin
            jerk_ff[0] <= to_signed(lane_x);
            jerk_ff[1] <= to_signed(lane_y);
            jerk_ff[2] <= to_signed(lane_z);
            axis_ff    <= tajtd_pkg::AxisX;
            valid_ff   <= 1'b1;
         end else if (valid_ff && rsp_ready) begin
            if (axis_ff == tajtd_pkg::AxisZ) begin
               valid_ff <= 1'b0;
            end else begin
               axis_ff <= axis_ff + 2'd1;
            end
         end
      end
   end

   assign idle = !valid_ff;
   assign rsp_valid = valid_ff;
   assign rsp_axis = axis_ff;
   assign rsp_jerk_value = (axis_ff == tajtd_pkg::AxisX) ? jerk_ff[0] :
                           (axis_ff == tajtd_pkg::AxisY) ? jerk_ff[1] : jerk_ff[2];
   assign rsp_last = (axis_ff == tajtd_pkg::AxisZ);

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      lanes_done |-> !valid_ff) else $error("new run while old run pending");
   a_axis_range: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> axis_ff != 2'd3) else $error("axis out of range");
   a_run_order: assert property (@(posedge clock) disable iff (reset)
      valid_ff && rsp_ready && !rsp_last |=> valid_ff) else $error("run cut short");

endmodule

>>> design/three_axis_jerk_threshold_detector_top.sv
// ----------------------------------------------------------------------------
// three_axis_jerk_threshold_detector_top: accelerometer jerk alert block
// Three axis lanes divide in parallel; a merge stage checks the threshold.
// ----------------------------------------------------------------------------
// Each request transfer carries one accelerometer sample and its millisecond
// time stamp. The block keeps the previous sample and time stamp, takes dt as
// the wrapping 32-bit difference, and for each axis computes the jerk
// diff*125/dt truncated toward zero in Q8 g/s. When the magnitude of any axis
// is strictly above csr_jerk_threshold, three response transfers follow in the
// order X, Y, Z, the last one with rsp_last set. A sample with zero dt causes
// nothing and leaves the stored state alone. From the request transfer to the
// first response, each lane captures the sample, multiplies by 125 and runs
// the restoring divider one quotient bit a cycle, and the merge stage then
// registers the threshold compare. The next request is taken once the lanes
// are free and any earlier alert run has fully left, so a busy response side
// holds off new samples.
module three_axis_jerk_threshold_detector_top (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic signed [tajtd_pkg::SampleWidth-1:0] req_accel_x,
   input  logic signed [tajtd_pkg::SampleWidth-1:0] req_accel_y,
   input  logic signed [tajtd_pkg::SampleWidth-1:0] req_accel_z,
   input  logic [tajtd_pkg::TimeWidth-1:0]       req_time_ms,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [1:0]                            rsp_axis,
   output logic signed [tajtd_pkg::JerkWidth-1:0] rsp_jerk_value,
   output logic                                  rsp_last,
   input  logic                                  csr_write,
   input  logic [tajtd_pkg::ThreshWidth-1:0]     csr_jerk_threshold
);

   logic [tajtd_pkg::ThreshWidth-1:0]        thresh_ff;
   logic signed [tajtd_pkg::SampleWidth-1:0] prev_x_ff, prev_y_ff, prev_z_ff;
   logic [tajtd_pkg::TimeWidth-1:0]          prev_time_ff;
   logic                                     busy_ff;

   logic [tajtd_pkg::TimeWidth-1:0] dt;
   logic                            accept;
   logic                            start;
   logic                            done_x, done_y, done_z;
   logic                            merge_idle;
   tajtd_pkg::lane_result_type      res_x, res_y, res_z;

   // The lanes and the merge stage both have to be free before a new sample.
   assign req_ready = !busy_ff && merge_idle;
   assign accept = req_valid && req_ready;
   assign dt = req_time_ms - prev_time_ff;
   // A zero dt sample is taken and dropped without touching any state.
   assign start = accept && (dt != '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff    <= tajtd_pkg::ThreshReset;
         prev_x_ff    <= '0;
         prev_y_ff    <= '0;
         prev_z_ff    <= '0;
         prev_time_ff <= '0;
         busy_ff      <= 1'b0;
      end else begin
         if (csr_write) begin
            thresh_ff <= csr_jerk_threshold;
         end
         if (start) begin
            prev_x_ff    <= req_accel_x;
            prev_y_ff    <= req_accel_y;
            prev_z_ff    <= req_accel_z;
            prev_time_ff <= req_time_ms;
            busy_ff      <= 1'b1;
         end else if (done_x) begin
            busy_ff <= 1'b0;
         end
      end
   end

   tajtd_lane u_lane_x (
      .clock, .reset, .start,
      .now_sample(req_accel_x), .prev_sample(prev_x_ff), .dt,
      .done(done_x), .result(res_x)
   );

   tajtd_lane u_lane_y (
      .clock, .reset, .start,
      .now_sample(req_accel_y), .prev_sample(prev_y_ff), .dt,
      .done(done_y), .result(res_y)
   );

   tajtd_lane u_lane_z (
      .clock, .reset, .start,
      .now_sample(req_accel_z), .prev_sample(prev_z_ff), .dt,
      .done(done_z), .result(res_z)
   );

   tajtd_merge u_merge (
      .clock, .reset,
      .lanes_done(done_x),
      .lane_x(res_x), .lane_y(res_y), .lane_z(res_z),
      .threshold(thresh_ff),
      .idle(merge_idle),
      .rsp_valid, .rsp_ready, .rsp_axis, .rsp_jerk_value, .rsp_last
   );

   // The three lanes run in lock step and must finish together.
   a_lanes_lockstep: assert property (@(posedge clock) disable iff (reset)
      done_x == done_y && done_y == done_z) else $error("lanes out of step");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> !accept) else $error("sample taken while busy");
   a_done_when_busy: assert property (@(posedge clock) disable iff (reset)
      done_x |-> busy_ff) else $error("lane done while idle");

endmodule
